@@ sv/bdq_pkg.sv @@
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and constants for the bounded deque
// Store depth, field widths, operation and status codes, and the command and
// status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    KIND_PUSH_BACK  = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_DUMP       = 3'd3,
    KIND_CLEAR      = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_ELEM  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic             push_back;
    logic             push_front;
    logic             pop;
    logic             clear;
    logic             rd_en;
    logic [IDX_W-1:0] rd_off;
    logic             load_out;
    logic             out_last;
    status_t          out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] occ;
    logic             empty;
    logic             full;
  } dp_stat_t;

endpackage

@@ sv/bdq_ctrl.sv @@
// ----------------------------------------------------------------------------
// bdq_ctrl: deque controller
// Decodes input words, sequences dump reads one element per cycle while the
// output register is free, and owns the output valid flag.
// ----------------------------------------------------------------------------
module bdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_kind,
  output logic              out_valid,
  input  logic              out_ready,
  input  bdq_pkg::dp_stat_t stat,
  output bdq_pkg::dp_cmd_t  cmd
);
  import bdq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  state_t           state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             out_free;
  logic             accept;
  logic [CNT_W-1:0] occ_m1;
  logic [IDX_W-1:0] last_off;
  kind_t            kind;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign kind      = kind_t'(in_kind);
  assign occ_m1    = stat.occ - CNT_W'(1);
  assign last_off  = occ_m1[IDX_W-1:0];

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cnt_nxt       = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (kind) inside
            KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
              if (stat.full) begin
                cmd.load_out   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = STATUS_FULL;
                out_valid_nxt  = 1'b1;
              end else begin
                cmd.push_back  = (kind == KIND_PUSH_BACK);
                cmd.push_front = (kind == KIND_PUSH_FRONT);
              end
            end
            KIND_POP_FRONT: begin
              cmd.pop = !stat.empty;
            end
            KIND_DUMP: begin
              if (stat.empty) begin
                cmd.load_out   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = STATUS_EMPTY;
                out_valid_nxt  = 1'b1;
              end else begin
                // first element read straight away, rest walked in S_DUMP
                cmd.rd_en      = 1'b1;
                cmd.rd_off     = '0;
                cmd.load_out   = 1'b1;
                cmd.out_last   = (last_off == '0);
                cmd.out_status = STATUS_ELEM;
                out_valid_nxt  = 1'b1;
                cnt_nxt        = IDX_W'(1);
                if (last_off != '0) begin
                  state_nxt = S_DUMP;
                end
              end
            end
            KIND_CLEAR: begin
              cmd.clear = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          cmd.rd_en      = 1'b1;
          cmd.rd_off     = cnt_r;
          cmd.load_out   = 1'b1;
          cmd.out_last   = (cnt_r == last_off);
          cmd.out_status = STATUS_ELEM;
          out_valid_nxt  = 1'b1;
          cnt_nxt        = cnt_r + IDX_W'(1);
          if (cnt_r == last_off) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

endmodule

@@ sv/bdq_dpath.sv @@
// ----------------------------------------------------------------------------
// bdq_dpath: deque datapath
// Ring store with registered read, front pointer, occupancy and the output
// word registers.
// ----------------------------------------------------------------------------
module bdq_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bdq_pkg::dp_cmd_t                  cmd,
  input  logic signed [bdq_pkg::DATA_W-1:0] in_value,
  output bdq_pkg::dp_stat_t                 stat,
  output logic signed [bdq_pkg::DATA_W-1:0] out_item_value,
  output logic                              out_last,
  output logic [1:0]                        out_status
);
  import bdq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;
  logic              last_r;
  status_t           status_r;
  logic [IDX_W-1:0]  back_slot, pre_front, next_front, rd_slot, wr_addr;
  logic              wr_en;

  function automatic logic [IDX_W-1:0] add_mod(input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(DEPTH)) begin
      s = s - (IDX_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  assign back_slot  = add_mod(front_r, occ_r[IDX_W-1:0]);
  assign next_front = add_mod(front_r, IDX_W'(1));
  assign rd_slot    = add_mod(front_r, cmd.rd_off);
  assign pre_front  = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - IDX_W'(1);
  assign wr_en      = cmd.push_back || cmd.push_front;
  assign wr_addr    = cmd.push_front ? pre_front : back_slot;

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_value;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_slot];
    end
  end

  always_comb begin
    front_nxt = front_r;
    occ_nxt   = occ_r;
    if (cmd.clear) begin
      front_nxt = '0;
      occ_nxt   = '0;
    end else if (cmd.push_back) begin
      occ_nxt = occ_r + CNT_W'(1);
    end else if (cmd.push_front) begin
      front_nxt = pre_front;
      occ_nxt   = occ_r + CNT_W'(1);
    end else if (cmd.pop) begin
      front_nxt = next_front;
      occ_nxt   = occ_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      occ_r   <= '0;
    end else begin
      front_r <= front_nxt;
      occ_r   <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      last_r   <= cmd.out_last;
      status_r <= cmd.out_status;
    end
  end

  assign stat.occ       = occ_r;
  assign stat.empty     = (occ_r == '0);
  assign stat.full      = (occ_r == CNT_W'(DEPTH));
  assign out_item_value = (status_r == STATUS_ELEM) ? rd_data_r : '0;
  assign out_last       = last_r;
  assign out_status     = status_r;

endmodule

@@ sv/bounded_deque_push_pop_dump_core.sv @@
// ----------------------------------------------------------------------------
// bounded_deque_push_pop_dump_core: bounded double-ended queue
// Ring-buffer deque of signed 32-bit values with push back/front, pop front,
// dump and clear, on valid/ready channels.
// ----------------------------------------------------------------------------
// Push, pop and clear give no word, except a push on a full store, which
// returns one word flagged full. A dump of N stored values streams N words,
// front first, at one per cycle while the sink is ready; the controller walks
// the ring store's single registered read port in S_DUMP and takes no new
// input until the last word is loaded. A dump of an empty store gives one word
// flagged empty. A new input word is taken only when the output register is
// empty or being drained in that cycle. No clearing pass is run after reset.
module bounded_deque_push_pop_dump_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        in_kind,
  input  logic signed [bdq_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bdq_pkg::DATA_W-1:0] out_item_value,
  output logic                              out_last,
  output logic [1:0]                        out_status
);
  import bdq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bdq_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_value       (in_value),
    .stat           (stat),
    .out_item_value (out_item_value),
    .out_last       (out_last),
    .out_status     (out_status)
  );

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.occ <= CNT_W'(DEPTH))
    else $error("occupancy beyond store depth");

  a_no_take_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (!out_valid || out_ready))
    else $error("input taken while output word stalled");

  a_flag_word_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STATUS_ELEM) |-> (out_last && out_item_value == '0))
    else $error("empty or full word not single and zero");

  a_no_write_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> !(cmd.push_back || cmd.push_front || cmd.pop || cmd.clear))
    else $error("store update during dump read");

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for bounded_deque_push_pop_dump_core
// Feeds deque commands on the input channel and tracks the ring store in a
// local deque model. Every word on the output channel is checked in order
// against the words the model predicts. A directed table runs first. Random
// traffic then alternates between push-heavy and pop-heavy runs, with idling
// on both sides until the last stretch, which runs without idling.
// ----------------------------------------------------------------------------
module tb;
  import bdq_pkg::*;

  localparam int          RANDOM_WORDS  = 180;
  localparam int          CYCLE_LIMIT   = 600000;
  localparam int          DRAIN_CYCLES  = 200;
  localparam int          NUM_ROWS      = 28;
  localparam logic [2:0]  KIND_SPARE_LO  = 3'd5;
  localparam logic [2:0]  KIND_SPARE_MID = 3'd6;
  localparam logic [2:0]  KIND_SPARE_HI  = 3'd7;
  localparam logic [31:0] VAL_MIN = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;

  typedef struct {
    logic signed [DATA_W-1:0] item_value;
    logic                     last;
    status_t                  status;
  } dump_word_t;

  // typed rows carry their single expected word; all others use the model
  typedef struct {
    logic [2:0]  kind;
    logic [31:0] value;
    int          reps;
    bit          rnd_value;
    bit          typed;
    status_t     typed_status;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [2:0]               in_kind = KIND_PUSH_BACK;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_item_value;
  logic                     out_last;
  logic [1:0]               out_status;

  dump_word_t               expected_words [$];
  logic signed [DATA_W-1:0] ring_model [DEPTH];
  logic [IDX_W-1:0]         head_slot = '0;
  logic [CNT_W-1:0]         fill_level = '0;

  int  fail_count = 0;
  int  cycle_count = 0;
  int  words_sent = 0;
  int  send_idle_pct = 7;
  int  recv_stall_pct = 72;

  bounded_deque_push_pop_dump_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item_value (out_item_value),
    .out_last       (out_last),
    .out_status     (out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Model of the ring store; record=0 updates state only
  task automatic deque_apply(input logic [2:0] k, input logic [31:0] v, input bit record);
    dump_word_t       w;
    logic [IDX_W-1:0] slot;
    case (k)
      KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
        if (fill_level == CNT_W'(DEPTH)) begin
          w = '{item_value: '0, last: 1'b1, status: STATUS_FULL};
          if (record) expected_words.push_back(w);
        end else if (k == KIND_PUSH_BACK) begin
          slot = head_slot + fill_level[IDX_W-1:0];
          ring_model[slot] = v;
          fill_level = fill_level + 1'b1;
        end else begin
          head_slot = head_slot - 1'b1;
          ring_model[head_slot] = v;
          fill_level = fill_level + 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (fill_level != 0) begin
          head_slot = head_slot + 1'b1;
          fill_level = fill_level - 1'b1;
        end
      end
      KIND_DUMP: begin
        if (fill_level == 0) begin
          w = '{item_value: '0, last: 1'b1, status: STATUS_EMPTY};
          if (record) expected_words.push_back(w);
        end else begin
          for (int i = 0; i < int'(fill_level); i++) begin
            slot = head_slot + IDX_W'(i);
            w = '{item_value: ring_model[slot], last: (i == int'(fill_level) - 1),
                  status: STATUS_ELEM};
            if (record) expected_words.push_back(w);
          end
        end
      end
      KIND_CLEAR: begin
        head_slot = '0;
        fill_level = '0;
      end
      default: ;
    endcase
  endtask

  // Drive one command word and wait until it is taken
  task automatic send_word(input logic [2:0] k, input logic [31:0] v, input bit typed,
                           input status_t typed_status);
    dump_word_t w;
    if (words_sent == 120) begin
      send_idle_pct = 72;
      recv_stall_pct = 7;
    end else if (words_sent == 240) begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= k;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    deque_apply(k, v, !typed);
    if (typed) begin
      w = '{item_value: '0, last: 1'b1, status: typed_status};
      expected_words.push_back(w);
    end
  endtask

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    case (r)
      0, 1:    return VAL_MIN;
      2, 3:    return VAL_MAX;
      4:       return '0;
      5:       return '1;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin : out_check
    dump_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: item_value %0d last %0b status %0d",
               out_item_value, out_last, out_status);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_item_value !== want.item_value) begin
          $error("item_value: expected %0d, got %0d", want.item_value, out_item_value);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_last);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t   directed_rows [NUM_ROWS];
    int          r;
    int          n;
    bit          pop_heavy;
    logic [2:0]  k;
    logic [31:0] v;

    directed_rows = '{
      '{KIND_DUMP,       32'd0,        1,  1'b0, 1'b1, STATUS_EMPTY},
      '{KIND_POP_FRONT,  32'd0,        1,  1'b0, 1'b0, STATUS_ELEM},
      '{KIND_PUSH_BACK,  VAL_MAX,      1,  1'b0, 1'b0, STATUS_ELEM},
      '{KIND_PUSH_BACK,  VAL_MIN,      1,  1'b0, 1'b0, STATUS_ELEM},
      '{KIND_PUSH_FRONT, 32'd0,        1,  1'b0, 1'b0, STATUS_ELEM},
      '{KIND_PUSH_FRONT, 32'hFFFF_FFFF, 1, 1'b0, 1'b0, STATUS_ELEM},
      '{KIND_DUMP,       32'd0,        1,  1'b0, 1'b0, STATUS_ELEM},
      '{KIND_POP_FRONT,  32'd0,        1,  1'b0, 1'b0, STATUS_ELEM},
      '{KIND_DUMP,       32'd0,        1,  1'b0, 1'b0, STATUS_ELEM},
      '{KIND_SPARE_LO,   32'h5555_5555, 1, 1'b0, 1'b0, STATUS_ELEM},
      '{KIND_SPARE_MID,  32'hAAAA_AAAA, 1, 1'b0, 1'b0, STATUS_ELEM},
      '{KIND_SPARE_HI,   32'hFFFF_FFFF, 1, 1'b0, 1'b0, STATUS_ELEM},
      '{KIND_CLEAR,      32'd0,        1,  1'b0, 1'b0, STATUS_ELEM},
      '{KIND_DUMP,       32'd0,        1,  1'b0, 1'b1, STATUS_EMPTY},
      '{KIND_PUSH_FRONT, 32'h1234_5678, 1, 1'b0, 1'b0, STATUS_ELEM},
      '{KIND_PUSH_BACK,  32'hA5A5_A5A5, 1, 1'b0, 1'b0, STATUS_ELEM},
      '{KIND_DUMP,       32'd0,        1,  1'b0, 1'b0, STATUS_ELEM},
      '{KIND_CLEAR,      32'd0,        1,  1'b0, 1'b0, STATUS_ELEM},
      '{KIND_PUSH_BACK,  32'd0,        DEPTH, 1'b1, 1'b0, STATUS_ELEM},
      '{KIND_PUSH_BACK,  VAL_MAX,      1,  1'b0, 1'b1, STATUS_FULL},
      '{KIND_PUSH_FRONT, VAL_MIN,      1,  1'b0, 1'b1, STATUS_FULL},
      '{KIND_DUMP,       32'd0,        1,  1'b0, 1'b0, STATUS_ELEM},
      '{KIND_POP_FRONT,  32'd0,        1,  1'b0, 1'b0, STATUS_ELEM},
      '{KIND_PUSH_FRONT, 32'h0F0F_0F0F, 1, 1'b0, 1'b0, STATUS_ELEM},
      '{KIND_PUSH_FRONT, 32'd1,        1,  1'b0, 1'b1, STATUS_FULL},
      '{KIND_DUMP,       32'd0,        1,  1'b0, 1'b0, STATUS_ELEM},
      '{KIND_CLEAR,      32'd0,        1,  1'b0, 1'b0, STATUS_ELEM},
      '{KIND_POP_FRONT,  32'd0,        1,  1'b0, 1'b0, STATUS_ELEM}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      for (int j = 0; j < directed_rows[i].reps; j++) begin
        v = directed_rows[i].rnd_value ? pick_value() : directed_rows[i].value;
        send_word(directed_rows[i].kind, v, directed_rows[i].typed,
                  directed_rows[i].typed_status);
      end
    end

    // push-heavy runs fill the store, pop-heavy runs drain it again
    n = 0;
    pop_heavy = 1'b0;
    while (n < RANDOM_WORDS) begin
      if ($urandom_range(0, 39) == 0) pop_heavy = !pop_heavy;
      r = $urandom_range(0, 99);
      if (!pop_heavy) begin
        if (r < 40)      k = KIND_PUSH_BACK;
        else if (r < 70) k = KIND_PUSH_FRONT;
        else if (r < 82) k = KIND_POP_FRONT;
        else if (r < 94) k = KIND_DUMP;
        else if (r < 96) k = KIND_CLEAR;
        else             k = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      end else begin
        if (r < 15)      k = KIND_PUSH_BACK;
        else if (r < 25) k = KIND_PUSH_FRONT;
        else if (r < 75) k = KIND_POP_FRONT;
        else if (r < 90) k = KIND_DUMP;
        else if (r < 95) k = KIND_CLEAR;
        else             k = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      end
      send_word(k, pick_value(), 1'b0, STATUS_ELEM);
      if (k < KIND_SPARE_LO) n++;
    end
    in_valid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/bdq_pkg.sv
sv/bdq_ctrl.sv
sv/bdq_dpath.sv
sv/bounded_deque_push_pop_dump_core.sv
verif/tb.sv
